>>> design/hand_motion_gesture_classifier_assert.svh
// assertion macros shared by the gesture classifier checker
// no dependencies
`ifndef HAND_MOTION_GESTURE_CLASSIFIER_ASSERT_SVH
`define HAND_MOTION_GESTURE_CLASSIFIER_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define HMG_ASSERT_IMP(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// next-cycle implication checked outside reset
`define HMG_ASSERT_NXT(lbl, clk, rst, lhs, rhs) \
   lbl: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

>>> design/hmg_pkg.sv
// package for the hand motion gesture classifier
// types, codes and the arctangent table; no dependencies
package hmg_pkg;
   typedef struct packed {
      logic [15:0] box_x_center;
      logic [15:0] box_y_center;
      logic [15:0] box_height;
      logic [15:0] wrist_x;
      logic [15:0] wrist_y;
      logic [15:0] knuckle_x;
      logic [15:0] knuckle_y;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] scroll_code;
      logic [1:0] zoom_code;
      logic [1:0] slide_code;
   } rsp_payload_type;

   localparam logic [2:0] CSR_MOVE_FACTOR = 3'd0;
   localparam logic [2:0] CSR_ZOOM_FACTOR = 3'd1;
   localparam logic [2:0] CSR_SLIDE_THR   = 3'd2;
   localparam logic [2:0] CSR_WIN_LOW     = 3'd3;
   localparam logic [2:0] CSR_WIN_HIGH    = 3'd4;

   localparam logic [2:0] SCROLL_NONE  = 3'd0;
   localparam logic [2:0] SCROLL_RIGHT = 3'd1;
   localparam logic [2:0] SCROLL_UP    = 3'd2;
   localparam logic [2:0] SCROLL_LEFT  = 3'd3;
   localparam logic [2:0] SCROLL_DOWN  = 3'd4;
   localparam logic [1:0] ZOOM_NONE = 2'd0;
   localparam logic [1:0] ZOOM_OUT  = 2'd1;
   localparam logic [1:0] ZOOM_IN   = 2'd2;
   localparam logic [1:0] SLIDE_NONE  = 2'd0;
   localparam logic [1:0] SLIDE_LEFT  = 2'd1;
   localparam logic [1:0] SLIDE_RIGHT = 2'd2;

   // cordic iterations
   localparam int CORDIC_STEPS = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ANG_SCROLL,
      ST_ANG_SLIDE,
      ST_DONE,
      ST_OUT
   } state_type;

   // angle unit control
   typedef struct packed {
      logic        start;
      logic signed [16:0] vx;
      logic signed [16:0] vy;
   } cordic_cmd_type;

   typedef struct packed {
      logic        done;
      logic signed [8:0] angle;
   } cordic_rsp_type;

   // arctangent of 2^-i in Q.16 degrees
   function automatic logic [21:0] atan_q16(input logic [3:0] i);
      logic [21:0] r;
      case (i)
         4'd0:  r = 22'd2949120;
         4'd1:  r = 22'd1740967;
         4'd2:  r = 22'd919879;
         4'd3:  r = 22'd466945;
         4'd4:  r = 22'd234379;
         4'd5:  r = 22'd117305;
         4'd6:  r = 22'd58666;
         4'd7:  r = 22'd29335;
         4'd8:  r = 22'd14668;
         4'd9:  r = 22'd7334;
         4'd10: r = 22'd3667;
         4'd11: r = 22'd1833;
         4'd12: r = 22'd917;
         4'd13: r = 22'd458;
         4'd14: r = 22'd229;
         4'd15: r = 22'd115;
         default: r = 22'd0;
      endcase
      return r;
   endfunction
endpackage

>>> design/hmg_serial_mul.sv
// shift-add multiplier, two bits of the multiplier per cycle
// depends on hmg_pkg (import only)
module hmg_serial_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [AW-1:0]      a,
   input  logic [BW-1:0]      b,
   output logic               done,
   output logic [AW+BW-1:0]   product
);
   import hmg_pkg::*;
   localparam int CW = $clog2(BW/2 + 1);
   logic [AW+BW-1:0] acc_ff, acc_in;
   logic [AW+BW-1:0] mcand_ff, mcand_in;
   logic [BW-1:0]    mplier_ff, mplier_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [AW+BW-1:0] p0, p1;

   always_comb begin
      p0 = mplier_ff[0] ? mcand_ff : '0;
      p1 = mplier_ff[1] ? (mcand_ff << 1) : '0;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = {{BW{1'b0}}, a};
         mplier_in = b;
         cnt_in = CW'(BW/2);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + p0 + p1;
         mcand_in = mcand_ff << 2;
         mplier_in = mplier_ff >> 2;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

>>> design/hmg_cordic.sv
// iterative cordic vectoring unit giving atan2 in integer degrees
// depends on hmg_pkg
module hmg_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  hmg_pkg::cordic_cmd_type cmd,
   output hmg_pkg::cordic_rsp_type rsp
);
   import hmg_pkg::*;
   // |v| * 2^16 grows by at most 1.65x
   logic signed [35:0] x_ff, x_in, y_ff, y_in;
   logic signed [24:0] z_ff, z_in;
   logic [3:0]  i_ff, i_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        negx_ff, negx_in, negy_ff, negy_in, zero_ff, zero_in;
   logic signed [8:0] ang_ff, ang_in;
   logic signed [35:0] xs, ys;
   logic [16:0] ax, ay;
   logic signed [24:0] zr;
   logic [7:0]  r;
   logic signed [8:0] rs;

   function automatic logic signed [35:0] sdown(input logic signed [35:0] v,
                                               input logic [3:0] s);
      logic signed [35:0] m;
      m = v < 0 ? -v : v;
      m = m >>> s;
      return v < 0 ? -m : m;
   endfunction

   always_comb begin
      ax = cmd.vx[16] ? 17'(-cmd.vx) : 17'(cmd.vx);
      ay = cmd.vy[16] ? 17'(-cmd.vy) : 17'(cmd.vy);
      xs = sdown(x_ff, i_ff);
      ys = sdown(y_ff, i_ff);
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0;
      negx_in = negx_ff; negy_in = negy_ff; zero_in = zero_ff;
      ang_in = ang_ff;
      // final rounding and quadrant mapping
      zr = z_ff + 25'sd32768;
      if (z_ff < 0) r = 8'd0;
      else if ((zr >>> 16) > 25'sd90) r = 8'd90;
      else r = 8'(zr >>> 16);
      if (zero_ff) rs = '0;
      else if (!negx_ff) rs = negy_ff ? -9'(r) : 9'(r);
      else rs = negy_ff ? 9'(r) - 9'sd180 : 9'sd180 - 9'(r);
      if (cmd.start) begin
         x_in = 36'(ax) <<< 16;
         y_in = 36'(ay) <<< 16;
         z_in = '0;
         i_in = '0;
         negx_in = cmd.vx[16];
         negy_in = cmd.vy[16];
         zero_in = (cmd.vx == 0) && (cmd.vy == 0);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys; y_in = y_ff - xs;
            z_in = z_ff + 25'(atan_q16(i_ff));
         end else begin
            x_in = x_ff - ys; y_in = y_ff + xs;
            z_in = z_ff - 25'(atan_q16(i_ff));
         end
         i_in = i_ff + 1'b1;
         if (i_ff == 4'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      if (done_ff) ang_in = rs;
   end

   logic fin_ff;
   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in;
      negx_ff <= negx_in; negy_ff <= negy_in; zero_ff <= zero_in;
      ang_ff <= ang_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; fin_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; fin_ff <= done_ff;
      end
   end

   assign rsp.done = fin_ff;
   assign rsp.angle = ang_ff;
endmodule

>>> design/hand_motion_gesture_classifier.sv
// top level of the hand motion gesture classifier
// depends on hmg_pkg, hmg_serial_mul, hmg_cordic
//
// usage: one frame is taken per req transaction (req_valid high, req_stall
// low); exactly one result comes back per frame on the rsp channel with
// scroll, zoom and slide codes. the block works on one frame at a time;
// req_stall is high from acceptance until the result has been taken.
// on the first frame the block goes straight to the decision and output
// steps; later frames first run the five serial products (move threshold,
// its square, zoom threshold, dx squared, dy squared), each at two bits a
// cycle, before the decision and output steps. a 16-iteration cordic run
// is added for the scroll angle when the center moved far enough, and one
// for the hand angle on every second frame.
// reset clears all history, restores register defaults and clears the
// result valid flag. when the receiver holds rsp_stall the result stays on
// rsp_payload and no new frame is taken until it leaves.
// csr writes are taken at any time through csr_valid/csr_ready; they are
// meant only while the block is idle.
module hand_motion_gesture_classifier (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hmg_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hmg_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data
);
   import hmg_pkg::*;

   logic [15:0] move_f_ff, zoom_f_ff;
   logic [7:0]  thr_ff;
   logic signed [8:0] wlo_ff, whi_ff;

   logic [15:0] lx_ff, ly_ff, lh_ff;
   logic        have_frame_ff, have_ang_ff, parity_ff;
   logic signed [8:0] lang_ff;
   req_payload_type cur_ff;
   rsp_payload_type out_ff;
   logic        rsp_valid_ff;
   state_type   st_ff, st_in;
   logic [1:0]  mstep_ff;
   logic [31:0] t_ff;
   logic [33:0] tz_ff;
   logic [32:0] d2_ff;

   // shared multiplier
   logic        m_start;
   logic [31:0] m_a, m_b;
   logic        m_done;
   logic [63:0] m_p;
   hmg_serial_mul #(.AW(32), .BW(32)) u_mul (
      .clock(clock), .reset(reset), .start(m_start), .a(m_a), .b(m_b),
      .done(m_done), .product(m_p));

   cordic_cmd_type ccmd;
   cordic_rsp_type crsp;
   hmg_cordic u_cordic (.clock(clock), .reset(reset), .cmd(ccmd), .rsp(crsp));

   logic signed [16:0] dx, dy, hx, hy;
   logic accept;
   logic [33:0] hs, ps;

   assign accept = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign req_stall = (st_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      dx = 17'(cur_ff.box_x_center) - 17'(lx_ff);
      dy = 17'(ly_ff) - 17'(cur_ff.box_y_center);
      hx = 17'(cur_ff.knuckle_x) - 17'(cur_ff.wrist_x);
      hy = 17'(cur_ff.wrist_y) - 17'(cur_ff.knuckle_y);
      hs = 34'(cur_ff.box_height) << 16;
      ps = 34'(lh_ff) << 16;
   end

   logic        dyphase_ff;

   // mul sequence: 0 t, 1 t*t, 2 tz, then d2 from dx*dx and dy*dy
   logic [16:0] adx, ady;
   always_comb begin
      adx = dx[16] ? 17'(-dx) : 17'(dx);
      ady = dy[16] ? 17'(-dy) : 17'(dy);
      m_a = '0; m_b = '0;
      case (mstep_ff)
         2'd0: begin m_a = 32'(move_f_ff); m_b = 32'(cur_ff.box_height); end
         2'd1: begin m_a = t_ff; m_b = t_ff; end
         2'd2: begin m_a = 32'(zoom_f_ff); m_b = 32'(cur_ff.box_height); end
         2'd3: begin
            m_a = dyphase_ff ? 32'(ady) : 32'(adx);
            m_b = dyphase_ff ? 32'(ady) : 32'(adx);
         end
         default: ;
      endcase
   end

   logic [31:0] tt_ff;
   logic [2:0]  scroll_ff;
   logic [1:0]  zoom_c, slide_c;
   logic signed [10:0] lo_b, hi_b;

   always_comb begin
      zoom_c = ZOOM_NONE;
      if (have_frame_ff) begin
         if (hs + tz_ff < ps) zoom_c = ZOOM_OUT;
         else if (hs > ps + tz_ff) zoom_c = ZOOM_IN;
      end
      slide_c = SLIDE_NONE;
      lo_b = 11'(lang_ff) - 11'(thr_ff);
      hi_b = 11'(lang_ff) + 11'(thr_ff);
      if (have_ang_ff && lang_ff >= wlo_ff && lang_ff <= whi_ff) begin
         if (11'(crsp.angle) > hi_b) slide_c = SLIDE_LEFT;
         else if (11'(crsp.angle) < lo_b) slide_c = SLIDE_RIGHT;
      end
   end

   logic [2:0] sc;
   always_comb begin
      if (crsp.angle >= -9'sd45 && crsp.angle < 9'sd45) sc = SCROLL_RIGHT;
      else if (crsp.angle >= 9'sd45 && crsp.angle < 9'sd135) sc = SCROLL_UP;
      else if (crsp.angle >= 9'sd135 || crsp.angle < -9'sd135) sc = SCROLL_LEFT;
      else sc = SCROLL_DOWN;
   end

   logic m_go_ff;
   always_comb begin
      st_in = st_ff;
      m_start = m_go_ff;
      ccmd = '0;
      case (st_ff)
         ST_IDLE: if (accept) st_in = have_frame_ff ? ST_MUL : ST_DONE;
         ST_MUL: begin
            if (m_done && mstep_ff == 2'd3 && dyphase_ff) begin
               if ((d2_ff + m_p[32:0]) > 33'(tt_ff)) begin
                  ccmd.start = 1'b1; ccmd.vx = dx; ccmd.vy = dy;
                  st_in = ST_ANG_SCROLL;
               end else st_in = ST_DONE;
            end
         end
         ST_ANG_SCROLL: if (crsp.done) st_in = ST_DONE;
         ST_DONE: begin
            if (!parity_ff) st_in = ST_OUT;
            else begin
               ccmd.start = 1'b1; ccmd.vx = hx; ccmd.vy = hy;
               st_in = ST_ANG_SLIDE;
            end
         end
         ST_ANG_SLIDE: if (crsp.done) st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   logic [1:0] slide_ff;

   always_ff @(posedge clock) begin
      if (accept) cur_ff <= req_payload;
      if (st_ff == ST_IDLE && accept) begin
         mstep_ff <= 2'd0; dyphase_ff <= 1'b0; scroll_ff <= SCROLL_NONE;
         slide_ff <= SLIDE_NONE; tz_ff <= '0;
      end
      if (st_ff == ST_MUL && m_done) begin
         case (mstep_ff)
            2'd0: begin t_ff <= m_p[31:0]; mstep_ff <= 2'd1; end
            2'd1: begin tt_ff <= m_p[63:32]; mstep_ff <= 2'd2; end
            2'd2: begin tz_ff <= 34'(m_p[32:0]); mstep_ff <= 2'd3; end
            2'd3: begin
               d2_ff <= m_p[32:0];
               dyphase_ff <= 1'b1;
            end
            default: ;
         endcase
      end
      if (st_ff == ST_ANG_SCROLL && crsp.done) scroll_ff <= sc;
      if (st_ff == ST_ANG_SLIDE && crsp.done) slide_ff <= slide_c;
      if (reset) begin
         st_ff <= ST_IDLE; rsp_valid_ff <= 1'b0; m_go_ff <= 1'b0;
         have_frame_ff <= 1'b0; have_ang_ff <= 1'b0; parity_ff <= 1'b0;
         lx_ff <= '0; ly_ff <= '0; lh_ff <= '0; lang_ff <= '0;
         move_f_ff <= 16'd1311; zoom_f_ff <= 16'd1966; thr_ff <= 8'd12;
         wlo_ff <= 9'sd80; whi_ff <= 9'sd100;
      end else begin
         st_ff <= st_in;
         // kick the multiplier on entry and after each product but the last
         m_go_ff <= (st_ff == ST_IDLE && accept && have_frame_ff) ||
                    (st_ff == ST_MUL && m_done && !(mstep_ff == 2'd3 && dyphase_ff));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MOVE_FACTOR: move_f_ff <= csr_data;
               CSR_ZOOM_FACTOR: zoom_f_ff <= csr_data;
               CSR_SLIDE_THR:   thr_ff <= csr_data[7:0];
               CSR_WIN_LOW:     wlo_ff <= csr_data[8:0];
               CSR_WIN_HIGH:    whi_ff <= csr_data[8:0];
               default: ;
            endcase
         end
         if (st_ff == ST_ANG_SLIDE && crsp.done) begin
            lang_ff <= crsp.angle; have_ang_ff <= 1'b1;
         end
         if (st_ff == ST_OUT) begin
            out_ff.scroll_code <= scroll_ff;
            out_ff.zoom_code <= zoom_c;
            out_ff.slide_code <= slide_ff;
            rsp_valid_ff <= 1'b1;
            lx_ff <= cur_ff.box_x_center; ly_ff <= cur_ff.box_y_center;
            lh_ff <= cur_ff.box_height; have_frame_ff <= 1'b1;
            parity_ff <= ~parity_ff;
         end else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end
endmodule

>>> design/hmg_checker.sv
// port-level checker for the gesture classifier, bound to the top level
// depends on hmg_pkg and hand_motion_gesture_classifier_assert.svh
`include "hand_motion_gesture_classifier_assert.svh"
module hmg_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_stall,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input hmg_pkg::rsp_payload_type rsp_payload
);
   import hmg_pkg::*;
   `HMG_ASSERT_IMP(a_scroll_legal, clock, reset, rsp_valid,
      rsp_payload.scroll_code <= SCROLL_DOWN)
   `HMG_ASSERT_IMP(a_zoom_legal, clock, reset, rsp_valid,
      rsp_payload.zoom_code <= ZOOM_IN)
   `HMG_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, req_stall)
   `HMG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
endmodule

bind hand_motion_gesture_classifier hmg_checker u_hmg_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload));

>>> sim/tb_hand_motion_gesture_classifier.sv
// testbench for the hand motion gesture classifier: random and directed frames,
// scoreboard against an in-bench gesture predictor; depends on hmg_pkg and the rtl top
module tb_hand_motion_gesture_classifier;
   timeunit 1ns;
   timeprecision 1ps;
   import hmg_pkg::*;

   // register index outside the list, must be ignored
   localparam logic [2:0] CSR_UNUSED = 3'd7;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, csr_valid, csr_ready;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic [2:0] csr_index;
   logic [15:0] csr_data;

   hand_motion_gesture_classifier u_dut (.*);

   // predictor copy of registers and history
   logic [15:0] p_move = 16'd1311, p_zoom = 16'd1966;
   logic [7:0] p_thr = 8'd12;
   int p_win_lo = 80, p_win_hi = 100;
   logic [15:0] h_cx = '0, h_cy = '0, h_h = '0;
   bit h_frame = 0, h_ang_ok = 0, h_parity = 0;
   int h_ang = 0;
   // base of the generated hand motion
   logic [15:0] gen_cx = '0, gen_cy = '0, gen_h = '0;

   req_payload_type frame_q[$];
   rsp_payload_type gesture_q[$];
   int n_mismatch, n_results, n_scroll, n_zoom, n_slide;
   longint cycles = 0;
   bit quiet, pause_gaps;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic longint trunc_shr(longint v, int s);
      return v >= 0 ? (v >>> s) : -((-v) >>> s);
   endfunction

   function automatic int cordic_deg(int dx, int dy);
      longint x, y, z, xs, ys, r;
      longint tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                          29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
      if (dx == 0 && dy == 0) return 0;
      x = longint'(dx < 0 ? -dx : dx) * 65536;
      y = longint'(dy < 0 ? -dy : dy) * 65536;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         xs = trunc_shr(x, i);
         ys = trunc_shr(y, i);
         if (y > 0) begin
            x += ys; y -= xs; z += tab[i];
         end else begin
            x -= ys; y += xs; z -= tab[i];
         end
      end
      r = (z < 0) ? 0 : ((z + 32768) >>> 16);
      if (r > 90) r = 90;
      if (dx >= 0) return dy >= 0 ? int'(r) : -int'(r);
      return dy >= 0 ? 180 - int'(r) : int'(r) - 180;
   endfunction

   function automatic rsp_payload_type classify_frame(req_payload_type f);
      rsp_payload_type g;
      longint dx, dy, a;
      longint unsigned d2, t, tz, hs, ps;
      g = '{SCROLL_NONE, ZOOM_NONE, SLIDE_NONE};
      if (h_frame) begin
         dx = longint'(f.box_x_center) - longint'(h_cx);
         dy = longint'(h_cy) - longint'(f.box_y_center);
         d2 = dx * dx + dy * dy;
         t = longint'(p_move) * f.box_height;
         tz = longint'(p_zoom) * f.box_height;
         hs = longint'(f.box_height) << 16;
         ps = longint'(h_h) << 16;
         if (d2 > ((t * t) >> 32)) begin
            a = cordic_deg(int'(dx), int'(dy));
            if (a >= -45 && a < 45) g.scroll_code = SCROLL_RIGHT;
            else if (a >= 45 && a < 135) g.scroll_code = SCROLL_UP;
            else if (a >= 135 || a < -135) g.scroll_code = SCROLL_LEFT;
            else g.scroll_code = SCROLL_DOWN;
         end
         if (hs + tz < ps) g.zoom_code = ZOOM_OUT;
         else if (hs > ps + tz) g.zoom_code = ZOOM_IN;
      end
      h_cx = f.box_x_center; h_cy = f.box_y_center; h_h = f.box_height;
      h_frame = 1;
      h_parity = ~h_parity;
      if (!h_parity) begin
         a = cordic_deg(int'(f.knuckle_x) - int'(f.wrist_x),
                        int'(f.wrist_y) - int'(f.knuckle_y));
         if (h_ang_ok && h_ang >= p_win_lo && h_ang <= p_win_hi) begin
            if (a > h_ang + int'(p_thr)) g.slide_code = SLIDE_LEFT;
            else if (a < h_ang - int'(p_thr)) g.slide_code = SLIDE_RIGHT;
         end
         h_ang = int'(a);
         h_ang_ok = 1;
      end
      return g;
   endfunction

   // driver
   int gap_left;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
         req_payload <= '0;
         gap_left = 0;
      end else if (req_valid && !req_stall) begin
         gesture_q.push_back(classify_frame(req_payload));
         if (!quiet && $urandom_range(3) == 0) gap_left = $urandom_range(1, 3);
         if (frame_q.size() > 0 && gap_left == 0 && !pause_gaps) begin
            req_payload <= frame_q.pop_front();
         end else begin
            req_valid <= 0;
         end
      end else if (!req_valid) begin
         if (gap_left > 0) gap_left--;
         if (gap_left == 0 && frame_q.size() > 0 && !pause_gaps) begin
            req_valid <= 1;
            req_payload <= frame_q.pop_front();
         end
      end
   end

   // monitor and receiver stall bursts
   int stall_left;
   always @(posedge clock) begin
      cycles++;
      if (reset) begin
         rsp_stall <= 0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (gesture_q.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10) $display("unexpected gesture transaction %p", rsp_payload);
            end else begin
               rsp_payload_type e;
               e = gesture_q.pop_front();
               if (e.scroll_code != SCROLL_NONE) n_scroll++;
               if (e.zoom_code != ZOOM_NONE) n_zoom++;
               if (e.slide_code != SLIDE_NONE) n_slide++;
               if (e.scroll_code !== rsp_payload.scroll_code ||
                   e.zoom_code !== rsp_payload.zoom_code ||
                   e.slide_code !== rsp_payload.slide_code) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display("gesture mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                              e.scroll_code, e.zoom_code, e.slide_code,
                              rsp_payload.scroll_code, rsp_payload.zoom_code,
                              rsp_payload.slide_code);
               end
            end
         end
         if (stall_left > 0) stall_left--;
         else if (!quiet && $urandom_range(5) == 0) stall_left = $urandom_range(1, 3);
         rsp_stall <= (stall_left > 0);
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > 2000000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      case (idx)
         CSR_MOVE_FACTOR: p_move = val;
         CSR_ZOOM_FACTOR: p_zoom = val;
         CSR_SLIDE_THR:   p_thr = val[7:0];
         CSR_WIN_LOW:     p_win_lo = $signed(val[8:0]);
         CSR_WIN_HIGH:    p_win_hi = $signed(val[8:0]);
         default: ;
      endcase
   endtask

   task automatic drain_frames();
      wait (frame_q.size() == 0 && !req_valid);
      while (gesture_q.size() > 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic req_payload_type rand_frame(int kind);
      req_payload_type f;
      f = 112'({$urandom, $urandom, $urandom, $urandom});
      if (kind == 1) begin
         // small motion around a box near the previous one
         f.box_x_center = gen_cx + 16'($urandom_range(0, 4000)) - 16'd2000;
         f.box_y_center = gen_cy + 16'($urandom_range(0, 4000)) - 16'd2000;
         f.box_height = gen_h + 16'($urandom_range(0, 1000)) - 16'd500;
         f.wrist_x = 16'd30000; f.wrist_y = 16'd40000;
         f.knuckle_x = 16'd30000 + 16'($urandom_range(0, 6000)) - 16'd3000;
         f.knuckle_y = 16'd30000 + 16'($urandom_range(0, 4000)) - 16'd2000;
      end
      return f;
   endfunction

   initial begin
      req_payload_type f;
      csr_valid = 0; csr_index = '0; csr_data = '0;
      quiet = 0; pause_gaps = 0;
      reset = 1;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, zero vector, the four directions, zoom both ways
      frame_q.push_back('0);
      frame_q.push_back('1);
      frame_q.push_back('{16'h8000, 16'h8000, 16'h1000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      frame_q.push_back('{16'h9000, 16'h8000, 16'h1000, 16'h8000, 16'h9000, 16'h8000, 16'h8000});
      frame_q.push_back('{16'h9000, 16'h7000, 16'h2000, 16'h8000, 16'h8000, 16'h9000, 16'h8000});
      frame_q.push_back('{16'h8000, 16'h7000, 16'h0100, 16'h8000, 16'h8000, 16'h8000, 16'h7000});
      frame_q.push_back('{16'h8000, 16'h8000, 16'h0100, 16'h8000, 16'h8000, 16'h7000, 16'h8000});
      frame_q.push_back('{16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'h0000});
      frame_q.push_back('{16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'h0000, 16'hffff});
      frame_q.push_back('{16'h0000, 16'hffff, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h8000});
      drain_frames();
      // extreme register settings, with window opened wide and an empty one
      csr_write(CSR_MOVE_FACTOR, 16'd0);
      csr_write(CSR_ZOOM_FACTOR, 16'hffff);
      csr_write(CSR_SLIDE_THR, 16'd0);
      csr_write(CSR_WIN_LOW, 16'h1ff & 16'(-180));
      csr_write(CSR_WIN_HIGH, 16'd180);
      csr_write(CSR_UNUSED, 16'h1234);
      for (int i = 0; i < 12; i++) frame_q.push_back(rand_frame($urandom_range(1)));
      drain_frames();
      csr_write(CSR_MOVE_FACTOR, 16'hffff);
      csr_write(CSR_ZOOM_FACTOR, 16'd0);
      csr_write(CSR_SLIDE_THR, 16'd180);
      csr_write(CSR_WIN_LOW, 16'd100);
      csr_write(CSR_WIN_HIGH, 16'd80);
      for (int i = 0; i < 12; i++) frame_q.push_back(rand_frame($urandom_range(1)));
      drain_frames();
      // random phases, each with fresh register settings
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_MOVE_FACTOR, 16'($urandom_range(0, 3000)));
         csr_write(CSR_ZOOM_FACTOR, 16'($urandom_range(0, 4000)));
         csr_write(CSR_SLIDE_THR, 16'($urandom_range(0, 30)));
         csr_write(CSR_WIN_LOW, 16'h1ff & 16'($urandom_range(0, 200) - 180));
         csr_write(CSR_WIN_HIGH, 16'($urandom_range(0, 180)));
         if (ph == 5) quiet = 1;
         for (int i = 0; i < 200; i++) begin
            // mostly coherent hand motion, some noise
            f = rand_frame(int'($urandom_range(3) != 0));
            frame_q.push_back(f);
            gen_cx = f.box_x_center; gen_cy = f.box_y_center; gen_h = f.box_height;
         end
         if (ph == 2) begin
            // hold the sender off until all gesture results are back
            pause_gaps = 1;
            while (gesture_q.size() > 0 || req_valid) @(posedge clock);
            pause_gaps = 0;
         end
         drain_frames();
      end
      $display("covered %0d gesture transactions: %0d scroll, %0d zoom, %0d slide",
               n_results, n_scroll, n_zoom, n_slide);
      $display("register settings varied over 8 phases including the extremes");
      if (n_mismatch == 0 && gesture_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
